[src/bu_pkg.sv]
package bu_pkg;

    // Image geometry and upscale factor.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int SCALE      = 3;
    localparam int PIXEL_MAX  = 255;

    // Field widths.
    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int DIM_W   = 9;
    localparam int CFG_IDX_W = 1;

    // Source memory addressing: address = row * MAX_WIDTH + col.
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;

    // Interpolation arithmetic.
    localparam int FRAC_W = $clog2(SCALE + 1);
    localparam int WGT_W  = $clog2(SCALE * SCALE + 1);
    localparam int SUM_W  = $clog2(PIXEL_MAX * SCALE * SCALE + 1);
    localparam int LIM_W  = DIM_W + $clog2(SCALE) + 1;

    // Reciprocal multipliers for the constant divisions.
    localparam int CRD_K       = COORD_W + $clog2(SCALE);
    localparam int CRD_RECIP   = (2 ** CRD_K + SCALE - 1) / SCALE;
    localparam int CRD_RECIP_W = $clog2(CRD_RECIP + 1);
    localparam int SUM_K       = SUM_W + $clog2(SCALE * SCALE);
    localparam int SUM_RECIP   = (2 ** SUM_K + SCALE * SCALE - 1) / (SCALE * SCALE);
    localparam int SUM_RECIP_W = $clog2(SUM_RECIP + 1);

    // Queue sizes (powers of two).
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int RQ_DEPTH = 8;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_QUERY,
        CMD_OUTSIDE
    } cmd_kind_t;

    typedef enum logic {
        ST_TOP_ROW,
        ST_BOTTOM_ROW
    } back_state_t;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   value;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             outside;
    } out_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [XW-1:0]     x;
        logic [YW-1:0]     y;
        logic [PIX_W-1:0]  value;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic              right_ok;
        logic              down_ok;
    } cmd_t;

endpackage

[src/bu_front.sv]
module bu_front (
    input  logic [bu_pkg::DIM_W-1:0] image_width,
    input  logic [bu_pkg::DIM_W-1:0] image_height,
    input  logic                     req_valid,
    input  bu_pkg::in_t              req_data,
    output logic                     req_ready,
    input  logic                     cmd_full,
    output logic                     cmd_push,
    output bu_pkg::cmd_t             cmd
);
    import bu_pkg::*;

    logic [DIM_W-1:0]               w_eff;
    logic [DIM_W-1:0]               h_eff;
    logic [LIM_W-1:0]               w_lim;
    logic [LIM_W-1:0]               h_lim;
    logic [COORD_W+CRD_RECIP_W-1:0] col_prod;
    logic [COORD_W+CRD_RECIP_W-1:0] row_prod;
    logic [COORD_W-1:0]             col_q;
    logic [COORD_W-1:0]             row_q;
    logic [COORD_W-1:0]             col_r;
    logic [COORD_W-1:0]             row_r;
    logic                           load_ok;
    logic                           in_image;

    always_comb
    begin
        w_eff = (int'(image_width) < MAX_WIDTH) ? image_width : DIM_W'(MAX_WIDTH);
        h_eff = (int'(image_height) < MAX_HEIGHT) ? image_height : DIM_W'(MAX_HEIGHT);
        w_lim = LIM_W'(w_eff) * LIM_W'(SCALE);
        h_lim = LIM_W'(h_eff) * LIM_W'(SCALE);

        // Division by the scale factor through a reciprocal multiply.
        col_prod = (COORD_W+CRD_RECIP_W)'(req_data.col)
                 * (COORD_W+CRD_RECIP_W)'(CRD_RECIP);
        row_prod = (COORD_W+CRD_RECIP_W)'(req_data.row)
                 * (COORD_W+CRD_RECIP_W)'(CRD_RECIP);
        col_q = COORD_W'(col_prod >> CRD_K);
        row_q = COORD_W'(row_prod >> CRD_K);
        col_r = req_data.col - COORD_W'(col_q * COORD_W'(SCALE));
        row_r = req_data.row - COORD_W'(row_q * COORD_W'(SCALE));

        load_ok  = (LIM_W'(req_data.col) < LIM_W'(w_eff))
                && (LIM_W'(req_data.row) < LIM_W'(h_eff));
        in_image = (LIM_W'(req_data.col) < w_lim) && (LIM_W'(req_data.row) < h_lim);

        cmd.value    = req_data.value;
        cmd.fx       = FRAC_W'(col_r);
        cmd.fy       = FRAC_W'(row_r);
        cmd.right_ok = (LIM_W'(col_q) + LIM_W'(1)) < LIM_W'(w_eff);
        cmd.down_ok  = (LIM_W'(row_q) + LIM_W'(1)) < LIM_W'(h_eff);

        if (req_data.op == OP_LOAD)
        begin
            cmd.kind = CMD_WRITE;
            cmd.x    = req_data.col[XW-1:0];
            cmd.y    = req_data.row[YW-1:0];
        end
        else
        begin
            cmd.kind = in_image ? CMD_QUERY : CMD_OUTSIDE;
            cmd.x    = col_q[XW-1:0];
            cmd.y    = row_q[YW-1:0];
        end

        req_ready = !cmd_full;
        // Out-of-range loads are accepted and dropped here.
        cmd_push  = req_valid && req_ready && ((req_data.op == OP_QUERY) || load_ok);
    end

endmodule

[src/bu_cmd_fifo.sv]
module bu_cmd_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  bu_pkg::cmd_t cmd_in,
    input  logic         pop,
    output bu_pkg::cmd_t head,
    output logic         empty,
    output logic         full
);
    import bu_pkg::*;

    cmd_t                mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_next;
    logic [CQ_PTR_W:0]   count_reg;
    logic [CQ_PTR_W:0]   count_next;

    always_comb
    begin
        empty       = (count_reg == '0);
        full        = (count_reg == (CQ_PTR_W+1)'(CQ_DEPTH));
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (CQ_PTR_W+1)'(push) - (CQ_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/bu_back.sv]
module bu_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_empty,
    input  bu_pkg::cmd_t head,
    output logic         cmd_pop,
    output logic         rsp_valid,
    input  logic         rsp_ready,
    output bu_pkg::out_t rsp_data
);
    import bu_pkg::*;

    // Source image, one write port and two read ports.
    logic [PIX_W-1:0] image_mem [2 ** AW];
    logic [PIX_W-1:0] rd_a_reg;
    logic [PIX_W-1:0] rd_b_reg;

    back_state_t state_reg;
    back_state_t state_next;

    logic          credit;
    logic          mem_we;
    logic          launch;
    logic          launch_outside;
    logic          rd_bottom;
    logic [YW-1:0] rd_y;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [AW-1:0] wr_addr;

    logic [RQ_CNT_W-1:0] pending_reg;
    logic [RQ_CNT_W-1:0] pending_next;

    logic [FRAC_W-1:0] gx;
    logic [FRAC_W-1:0] gy;

    // Launch stage: weights with out-of-image neighbours zeroed.
    logic             s0_valid_reg;
    logic             s0_outside_reg;
    logic [WGT_W-1:0] s0_w00_reg;
    logic [WGT_W-1:0] s0_w10_reg;
    logic [WGT_W-1:0] s0_w01_reg;
    logic [WGT_W-1:0] s0_w11_reg;

    // Top-row partial sum.
    logic             s1_valid_reg;
    logic             s1_outside_reg;
    logic [SUM_W-1:0] s1_top_reg;
    logic [SUM_W-1:0] s1_top_next;
    logic [WGT_W-1:0] s1_w01_reg;
    logic [WGT_W-1:0] s1_w11_reg;

    // Full weighted sum.
    logic             s2_valid_reg;
    logic             s2_outside_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [SUM_W-1:0] s2_sum_next;

    logic [SUM_W+SUM_RECIP_W-1:0] quo_prod;
    logic [SUM_W-1:0]             quo;
    out_t                         result;

    // Result queue.
    out_t                rq_mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] rq_wr_reg;
    logic [RQ_PTR_W-1:0] rq_rd_reg;
    logic [RQ_CNT_W-1:0] rq_count_reg;
    logic [RQ_CNT_W-1:0] rq_count_next;
    logic                rq_pop;

    assign credit = pending_reg < RQ_CNT_W'(RQ_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_TOP_ROW:
            begin
                if (!cmd_empty && (head.kind == CMD_QUERY) && credit)
                begin
                    state_next = ST_BOTTOM_ROW;
                end
            end
            ST_BOTTOM_ROW:
            begin
                state_next = ST_TOP_ROW;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        launch         = 1'b0;
        launch_outside = 1'b0;
        rd_bottom      = 1'b0;
        unique case (state_reg)
            ST_TOP_ROW:
            begin
                if (!cmd_empty)
                begin
                    unique case (head.kind)
                        CMD_WRITE:
                        begin
                            cmd_pop = 1'b1;
                            mem_we  = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            launch = credit;
                        end
                        CMD_OUTSIDE:
                        begin
                            cmd_pop        = credit;
                            launch         = credit;
                            launch_outside = credit;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_BOTTOM_ROW:
            begin
                cmd_pop   = 1'b1;
                rd_bottom = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rd_y      = rd_bottom ? YW'(head.y + 1'b1) : head.y;
        rd_addr_a = {rd_y, head.x};
        rd_addr_b = {rd_y, XW'(head.x + 1'b1)};
        wr_addr   = {head.y, head.x};
        gx        = FRAC_W'(SCALE) - head.fx;
        gy        = FRAC_W'(SCALE) - head.fy;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            image_mem[wr_addr] <= head.value;
        end
        rd_a_reg <= image_mem[rd_addr_a];
        rd_b_reg <= image_mem[rd_addr_b];
    end

    always_comb
    begin
        // A zero weight marks a neighbour off the image or with a zero fraction; its
        // read data is left out, since that entry may never have been loaded.
        s1_top_next = SUM_W'(rd_a_reg) * SUM_W'(s0_w00_reg)
                    + ((s0_w10_reg == '0) ? '0 : SUM_W'(rd_b_reg) * SUM_W'(s0_w10_reg));
        s2_sum_next = s1_top_reg
                    + ((s1_w01_reg == '0) ? '0 : SUM_W'(rd_a_reg) * SUM_W'(s1_w01_reg))
                    + ((s1_w11_reg == '0) ? '0 : SUM_W'(rd_b_reg) * SUM_W'(s1_w11_reg));
        quo_prod    = (SUM_W+SUM_RECIP_W)'(s2_sum_reg) * (SUM_W+SUM_RECIP_W)'(SUM_RECIP);
        quo         = SUM_W'(quo_prod >> SUM_K);
        if (s2_outside_reg)
        begin
            result.pixel = '0;
        end
        else if (quo > SUM_W'(PIXEL_MAX))
        begin
            result.pixel = PIX_W'(PIXEL_MAX);
        end
        else
        begin
            result.pixel = quo[PIX_W-1:0];
        end
        result.outside = s2_outside_reg;
    end

    always_ff @(posedge clk)
    begin
        s0_outside_reg <= launch_outside;
        s0_w00_reg     <= WGT_W'(gx) * WGT_W'(gy);
        s0_w10_reg     <= head.right_ok ? WGT_W'(head.fx) * WGT_W'(gy) : '0;
        s0_w01_reg     <= head.down_ok ? WGT_W'(gx) * WGT_W'(head.fy) : '0;
        s0_w11_reg     <= (head.right_ok && head.down_ok)
                        ? WGT_W'(head.fx) * WGT_W'(head.fy) : '0;
        s1_outside_reg <= s0_outside_reg;
        s1_top_reg     <= s1_top_next;
        s1_w01_reg     <= s0_w01_reg;
        s1_w11_reg     <= s0_w11_reg;
        s2_outside_reg <= s1_outside_reg;
        s2_sum_reg     <= s2_sum_next;
        if (s2_valid_reg)
        begin
            rq_mem_reg[rq_wr_reg] <= result;
        end
    end

    always_comb
    begin
        rsp_valid     = (rq_count_reg != '0);
        rsp_data      = rq_mem_reg[rq_rd_reg];
        rq_pop        = rsp_valid && rsp_ready;
        rq_count_next = rq_count_reg + RQ_CNT_W'(s2_valid_reg) - RQ_CNT_W'(rq_pop);
        pending_next  = pending_reg + RQ_CNT_W'(launch) - RQ_CNT_W'(rq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_TOP_ROW;
            pending_reg  <= '0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            rq_wr_reg    <= '0;
            rq_rd_reg    <= '0;
            rq_count_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            s0_valid_reg <= launch;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            rq_wr_reg    <= s2_valid_reg ? rq_wr_reg + 1'b1 : rq_wr_reg;
            rq_rd_reg    <= rq_pop ? rq_rd_reg + 1'b1 : rq_rd_reg;
            rq_count_reg <= rq_count_next;
        end
    end

endmodule

[src/bilinear_upscaler_core.sv]
// A query request gives its response after the command queue, the launch,
// top-row and full-sum stages and the result queue; loads give no response.
// An in-range query holds the back end for a top-row and then a bottom-row
// read of the image memory, whose two read ports take one pair at a time.
// Reset clears all control state and sets the image size to 256 x 256;
// the image memory is not cleared and holds no data until loaded.
module bilinear_upscaler_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  bu_pkg::in_t                  req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output bu_pkg::out_t                 rsp_data,
    input  logic                         cfg_we,
    input  logic [bu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bu_pkg::DIM_W-1:0]     cfg_data
);
    import bu_pkg::*;

    // Configuration registers. They are to be written only while the block is
    // idle, so the front end may use them directly. The block does not enforce it.
    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_width_next;
    logic [DIM_W-1:0] image_height_reg;
    logic [DIM_W-1:0] image_height_next;

    // Command queue between the front end and the back end.
    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_empty;
    cmd_t cmd;
    cmd_t cmd_head;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                REG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default:          image_width_next  = image_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // The front end classifies each request: a load in range becomes a
    // memory write, a query inside the upscaled image becomes a lookup with
    // its source position, fractions and edge flags worked out, and a query
    // outside becomes a flagged zero response. Out-of-range loads vanish.
    bu_front u_front (
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .req_valid    (req_valid),
        .req_data     (req_data),
        .req_ready    (req_ready),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    bu_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cmd_push),
        .cmd_in (cmd),
        .pop    (cmd_pop),
        .head   (cmd_head),
        .empty  (cmd_empty),
        .full   (cmd_full)
    );

    // The back end owns the image memory. A lookup reads the top pair of
    // neighbours, the bottom pair in the next cycle, and then runs a
    // short pipeline: weighted top row, full sum, divide by the squared
    // scale through a reciprocal multiply, and saturate. Results wait in a
    // small queue; a credit count keeps lookups from overrunning it.
    bu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .head      (cmd_head),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !cmd_full)
        else $error("command pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> !cmd_empty)
        else $error("command popped from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.outside) |-> (rsp_data.pixel == '0))
        else $error("outside response carries a nonzero pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && (cmd.kind == CMD_WRITE)) |-> (req_data.op == OP_LOAD))
        else $error("query request turned into a memory write");

endmodule

[tb/sv/bilinear_upscaler_core_test.sv]
`timescale 1ns / 1ps

module bilinear_upscaler_core_test;

    import bu_pkg::*;

    // Cycles allowed for loads still in flight once the last response is in.
    localparam int SETTLE_CYCLES = 16;
    // Cycles the response side holds off during the backpressure test.
    localparam int HOLD_CYCLES = 100;

    typedef struct {
        out_t        pixel_out;
        int unsigned col;
        int unsigned row;
    } pending_pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    in_t                  req_data = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    out_t                 rsp_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    // Shadow copy of the source image and of the size registers.
    logic [PIX_W-1:0] source_pixels [0:MAX_WIDTH*MAX_HEIGHT-1];
    bit               source_written [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // Interpolated pixels still owed by the block, oldest first.
    pending_pixel_t expected_pixels [$];

    int error_count = 0;
    int useful_count = 0;
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int rsp_hold_cycles = 0;

    bilinear_upscaler_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // The run must never get this far; a stuck handshake ends up here.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] d, input int unsigned lim);
        return (d < lim) ? d : lim;
    endfunction

    function automatic in_t make_request(input logic op, input int unsigned col,
                                         input int unsigned row, input int unsigned value);
        in_t r;
        r.op    = op;
        r.col   = COORD_W'(col);
        r.row   = COORD_W'(row);
        r.value = PIX_W'(value);
        return r;
    endfunction

    // Neighbour intensity; anything right of or below the image reads as 0.
    function automatic int unsigned neighbour(input int unsigned x, input int unsigned y,
                                              input int unsigned w, input int unsigned h);
        if (x >= w || y >= h)
            return 0;
        return source_pixels[y * MAX_WIDTH + x];
    endfunction

    // Exact integer bilinear interpolation: weights are multiples of 1/SCALE,
    // the sum is divided once by SCALE squared with truncation.
    function automatic out_t interpolate_pixel(input int unsigned col, input int unsigned row);
        int unsigned w;
        int unsigned h;
        int unsigned px;
        int unsigned py;
        int unsigned fx;
        int unsigned fy;
        int unsigned acc;
        out_t        res;
        w = dim_in_use(width_reg, MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        res.pixel   = '0;
        res.outside = 1'b0;
        if (col >= SCALE * w || row >= SCALE * h)
        begin
            res.outside = 1'b1;
            return res;
        end
        px  = col / SCALE;
        py  = row / SCALE;
        fx  = col % SCALE;
        fy  = row % SCALE;
        acc = neighbour(px, py, w, h) * (SCALE - fx) * (SCALE - fy)
            + neighbour(px + 1, py, w, h) * fx * (SCALE - fy)
            + neighbour(px, py + 1, w, h) * (SCALE - fx) * fy
            + neighbour(px + 1, py + 1, w, h) * fx * fy;
        acc = acc / (SCALE * SCALE);
        res.pixel = (acc > PIXEL_MAX) ? PIX_W'(PIXEL_MAX) : PIX_W'(acc);
        return res;
    endfunction

    // Applies one accepted request to the shadow state and records what a query
    // must answer. Loads outside the image in use are dropped by the block.
    function automatic void apply_request(input in_t r);
        int unsigned    w;
        int unsigned    h;
        pending_pixel_t p;
        w = dim_in_use(width_reg, MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        if (r.op == OP_LOAD)
        begin
            if (r.col < w && r.row < h)
            begin
                source_pixels[r.row * MAX_WIDTH + r.col]  = r.value;
                source_written[r.row * MAX_WIDTH + r.col] = 1'b1;
                useful_count++;
            end
        end
        else
        begin
            p.pixel_out = interpolate_pixel(r.col, r.row);
            p.col       = r.col;
            p.row       = r.row;
            expected_pixels.push_back(p);
            useful_count++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic check_response(input out_t got);
        pending_pixel_t p;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("unexpected response pixel %0d outside %0b",
                                      got.pixel, got.outside));
        end
        else
        begin
            p = expected_pixels.pop_front();
            if (got.pixel !== p.pixel_out.pixel)
                report_mismatch($sformatf("query (%0d,%0d) pixel %0d, expected %0d",
                                          p.col, p.row, got.pixel, p.pixel_out.pixel));
            if (got.outside !== p.pixel_out.outside)
                report_mismatch($sformatf("query (%0d,%0d) outside %0b, expected %0b",
                                          p.col, p.row, got.outside, p.pixel_out.outside));
        end
    endtask

    // Response side: a long hold-off when one is requested, random stalls
    // otherwise. Driven at the falling edge, checked at the rising edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_hold_cycles = rsp_hold_cycles - 1;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            check_response(rsp_data);
    end

    // Offers one request, starting and ending on a falling edge. Valid is left
    // high after acceptance so back-to-back requests need no extra edge.
    task automatic send_request(input in_t r);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = req_ready;
            if (taken)
                apply_request(r);
            @(negedge clk);
        end
    endtask

    task automatic load_pixel(input int unsigned x, input int unsigned y, input int unsigned v);
        send_request(make_request(OP_LOAD, x, y, v));
    endtask

    // Queries one output pixel. Any in-image neighbour that was never loaded is
    // loaded first, so the block never uses data from an unwritten memory entry.
    task automatic query_pixel(input int unsigned col, input int unsigned row);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        w = dim_in_use(width_reg, MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        if (col < SCALE * w && row < SCALE * h)
        begin
            for (int dy = 0; dy < 2; dy++)
            begin
                for (int dx = 0; dx < 2; dx++)
                begin
                    x = col / SCALE + dx;
                    y = row / SCALE + dy;
                    if (x < w && y < h && !source_written[y * MAX_WIDTH + x])
                        load_pixel(x, y, $urandom_range(255));
                end
            end
        end
        send_request(make_request(OP_QUERY, col, row, $urandom_range(255)));
    endtask

    // Stops offering requests until every response is in, then lets trailing
    // loads work their way through the pipeline.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Size registers are only written while the block is idle.
    task automatic set_size(input int unsigned w, input int unsigned h);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= DIM_W'(w);
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= DIM_W'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        width_reg  = DIM_W'(w);
        height_reg = DIM_W'(h);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
    endtask

    // Full-size image: corners, several fraction pairs, the far edge where the
    // right and lower neighbours fall off, and queries past the output image.
    task automatic test_corner_pixels();
        set_size(MAX_WIDTH, MAX_HEIGHT);
        load_pixel(0, 0, 255);
        load_pixel(1, 0, 0);
        load_pixel(0, 1, 128);
        load_pixel(1, 1, 255);
        query_pixel(0, 0);
        query_pixel(1, 1);
        query_pixel(2, 2);
        query_pixel(1, 2);
        load_pixel(255, 255, 255);
        load_pixel(254, 254, 1);
        load_pixel(255, 254, 200);
        load_pixel(254, 255, 77);
        query_pixel(767, 767);
        query_pixel(765, 764);
        query_pixel(766, 767);
        query_pixel(768, 0);
        query_pixel(0, 768);
        query_pixel(1023, 1023);
    endtask

    // Size register corner cases: zero width or height makes every query
    // outside, values above the maximum clamp to it, and a 2 x 2 image.
    task automatic test_size_extremes();
        set_size(0, MAX_HEIGHT);
        query_pixel(0, 0);
        load_pixel(0, 0, 9);
        set_size(MAX_WIDTH, 0);
        query_pixel(5, 5);
        set_size(511, 511);
        query_pixel(767, 767);
        query_pixel(768, 767);
        load_pixel(256, 0, 1);
        set_size(2, 2);
        query_pixel(5, 5);
        query_pixel(3, 4);
        query_pixel(6, 0);
        query_pixel(0, 6);
        query_pixel(4, 2);
    endtask

    // The response side holds off long enough for the block to fill and push
    // back on requests, then the sender pauses until everything has drained.
    task automatic test_backpressure();
        int unsigned w;
        int unsigned h;
        set_idling(0, 0);
        set_size(4, 4);
        w = dim_in_use(width_reg, MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        rsp_hold_cycles = HOLD_CYCLES;
        repeat (24)
            query_pixel($urandom_range(SCALE * w - 1), $urandom_range(SCALE * h - 1));
        wait_drained();
        repeat (6)
            query_pixel($urandom_range(SCALE * w - 1), $urandom_range(SCALE * h - 1));
    endtask

    // Mostly in-image queries with their neighbourhoods loaded on demand, mixed
    // with reloads, stray queries and loads the block must drop.
    task automatic random_burst(input int n);
        int          stop_at;
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        stop_at = useful_count + n;
        w = dim_in_use(width_reg, MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        while (useful_count < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                query_pixel($urandom_range(SCALE * w - 1), $urandom_range(SCALE * h - 1));
            else if (pick < 78)
                load_pixel($urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(255));
            else if (pick < 90)
                query_pixel($urandom_range(1023), $urandom_range(1023));
            else if (pick < 95)
                load_pixel($urandom_range(1023, w), $urandom_range(1023), $urandom_range(255));
            else
                load_pixel($urandom_range(1023), $urandom_range(1023, h), $urandom_range(255));
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(81, 0);
                2: set_idling(0, 81);
                default: set_idling(35, 35);
            endcase
            case (phase)
                0: set_size($urandom_range(12, 2), $urandom_range(12, 2));
                1: set_size(MAX_WIDTH, MAX_HEIGHT);
                2: set_size(2, $urandom_range(40, 2));
                default: set_size($urandom_range(40, 2), $urandom_range(40, 2));
            endcase
            random_burst(90);
        end
    endtask

    initial
    begin
        width_reg  = DIM_RESET;
        height_reg = DIM_RESET;
        for (int i = 0; i < MAX_WIDTH * MAX_HEIGHT; i++)
            source_written[i] = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corner_pixels();
        test_size_extremes();
        test_backpressure();
        test_random_traffic();

        set_idling(0, 0);
        wait_drained();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
